@@ hdl/mexp_pkg.sv @@
// Package for the modular exponentiation unit.
// Holds the controller state type, the command/status structs and register indexes.
// No dependencies.
`default_nettype none
package mexp_pkg;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] RegExponent = 1'b0;
    localparam logic [CfgIdxW-1:0] RegModulus  = 1'b1;

    typedef enum logic [2:0] {
        StIdle,
        StReduce,
        StCheck,
        StMul,
        StSqrGo,
        StSqr,
        StSqrWr,
        StDone
    } mexp_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture base, exponent, modulus
        logic red_step;   // one restoring-division step of base mod m
        logic mul_start;  // start acc*pw
        logic sqr_start;  // start pw*pw
        logic mm_step;    // one double-and-add step
        logic mul_wr;     // write product to acc
        logic sqr_wr;     // write product to pw and shift exponent
    } mexp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic red_last;
        logic mm_last;
        logic exp_zero;
        logic exp_lsb;
    } mexp_sts_t;
endpackage
`default_nettype wire

@@ hdl/modular_exponentiation_unit.sv @@
// Modular exponentiation unit: power_mod = base ^ exponent mod modulus.
// Depends on mexp_pkg, mexp_ctrl, mexp_seq, mexp_datapath.
`default_nettype none
// One base is taken at a time. The base is first reduced modulo the modulus
// by a WIDTH-step restoring division, then the exponent is scanned from its
// least significant bit: each set bit costs one modular multiply and every
// bit a modular square, each done by a bit-serial double-and-add multiplier
// of WIDTH steps. A square is started, stepped and written back; a
// multiply's writeback overlaps the start of the square after it. The
// multiplier is the only arithmetic unit. A modulus of 0 or 1 acts as 2;
// an exponent of 0 gives 1.
// Configuration must be written only while the unit is idle.
module modular_exponentiation_unit #(
    parameter int unsigned WIDTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [63:0]      cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [WIDTH-1:0] s_base,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [WIDTH-1:0] m_power_mod
);
    import mexp_pkg::*;

    logic [WIDTH-1:0] exp_reg, mod_reg;
    mexp_cmd_t cmd_raw, cmd;
    mexp_sts_t sts;
    logic busy, done, in_beat, out_free;
    logic [WIDTH-1:0] result;

    // Configuration registers hold the low WIDTH bits of each write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg <= '0;
            mod_reg <= WIDTH'(2);
        end else if (cfg_we) begin
            case (cfg_index)
                RegExponent: exp_reg <= cfg_data[WIDTH-1:0];
                RegModulus:  mod_reg <= cfg_data[WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Output register: a result waits here while the next base is accepted.
    assign out_free = !m_valid || m_ready;
    assign s_ready  = !busy;
    assign in_beat  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (done) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) m_power_mod <= result;
    end

    mexp_ctrl u_ctrl (
        .aclk, .aresetn, .in_beat, .out_free, .sts,
        .cmd(cmd_raw), .busy, .done
    );

    mexp_seq u_seq (
        .aclk, .aresetn, .cmd_in(cmd_raw), .sts, .cmd_out(cmd)
    );

    mexp_datapath #(.WIDTH(WIDTH)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .base_in(s_base), .exp_in(exp_reg), .mod_in(mod_reg), .result
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !in_beat) else $error("beat accepted while busy");
    a_done_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> out_free) else $error("result overwrote pending beat");
    a_valid_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> m_valid) else $error("result not presented");
`endif
endmodule
`default_nettype wire

@@ hdl/mexp_datapath.sv @@
// Datapath: operand registers, base reduction and a bit-serial modular multiplier.
// Depends on mexp_pkg.
`default_nettype none
module mexp_datapath #(
    parameter int unsigned WIDTH = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mexp_pkg::mexp_cmd_t cmd,
    output mexp_pkg::mexp_sts_t   sts,
    input  wire logic [WIDTH-1:0] base_in,
    input  wire logic [WIDTH-1:0] exp_in,
    input  wire logic [WIDTH-1:0] mod_in,
    output logic      [WIDTH-1:0] result
);
    import mexp_pkg::*;
    localparam int unsigned CntW = $clog2(WIDTH);

    logic [WIDTH-1:0] m_reg, e_reg, pw_reg, acc_reg;
    logic [WIDTH-1:0] base_reg;          // shifts out during reduction
    logic [WIDTH-1:0] a_reg, b_reg, r_reg;
    logic [CntW-1:0]  cnt_reg;
    logic [WIDTH-1:0] mod_cl;
    logic [WIDTH:0]   dbl, dsub, addv, asub;
    logic [WIDTH-1:0] r_dbl, r_next, rem_in;

    assign mod_cl = (mod_in < WIDTH'(2)) ? WIDTH'(2) : mod_in;

    // Double r (shifting in a base bit when reducing), then conditionally add a.
    assign rem_in = cmd.red_step ? WIDTH'(base_reg[WIDTH-1]) : '0;
    assign dbl    = {r_reg, 1'b0} | {1'b0, rem_in};
    assign dsub   = dbl - {1'b0, m_reg};
    assign r_dbl  = dsub[WIDTH] ? dbl[WIDTH-1:0] : dsub[WIDTH-1:0];
    assign addv   = {1'b0, r_dbl} + {1'b0, a_reg};
    assign asub   = addv - {1'b0, m_reg};
    assign r_next = (b_reg[WIDTH-1] && !cmd.red_step)
                  ? (asub[WIDTH] ? addv[WIDTH-1:0] : asub[WIDTH-1:0]) : r_dbl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.load || cmd.mul_start || cmd.sqr_start) begin
            cnt_reg <= '0;
        end else if (cmd.red_step || cmd.mm_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= mod_cl;
            e_reg    <= exp_in;
            base_reg <= base_in;
            r_reg    <= '0;
            acc_reg  <= WIDTH'(1);
        end
        if (cmd.red_step) begin
            r_reg    <= r_next;
            base_reg <= {base_reg[WIDTH-2:0], 1'b0};
            if (sts.red_last) pw_reg <= r_next;
        end
        if (cmd.mul_start) begin
            a_reg <= acc_reg; b_reg <= pw_reg; r_reg <= '0;
        end
        if (cmd.sqr_start) begin
            a_reg <= pw_reg;  b_reg <= pw_reg; r_reg <= '0;
        end
        if (cmd.mm_step) begin
            r_reg <= r_next;
            b_reg <= {b_reg[WIDTH-2:0], 1'b0};
        end
        if (cmd.mul_wr) acc_reg <= r_reg;
        if (cmd.sqr_wr) begin
            pw_reg <= r_reg;
            e_reg  <= e_reg >> 1;
        end
    end

    assign sts.red_last = (cnt_reg == CntW'(WIDTH-1));
    assign sts.mm_last  = (cnt_reg == CntW'(WIDTH-1));
    assign sts.exp_zero = (e_reg == '0);
    assign sts.exp_lsb  = e_reg[0];
    // acc = 1 is already reduced since m >= 2.
    assign result = acc_reg;
endmodule
`default_nettype wire

@@ hdl/mexp_ctrl.sv @@
// Controller state machine sequencing reduction, multiplies and squares.
// Depends on mexp_pkg.
`default_nettype none
module mexp_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_beat,
    input  wire logic            out_free,
    input  wire mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import mexp_pkg::*;
    mexp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= StIdle;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            StIdle:   if (in_beat) state_next = StReduce;
            StReduce: if (sts.red_last) state_next = StCheck;
            StCheck: begin
                if (sts.exp_zero)     state_next = StDone;
                else if (sts.exp_lsb) state_next = StMul;
                else                  state_next = StSqr;
            end
            StMul:    if (sts.mm_last) state_next = StSqrGo;
            // Multiply writeback lands here while the square is started.
            StSqrGo:  state_next = StSqr;
            StSqr:    if (sts.mm_last) state_next = StSqrWr;
            // Wait here for the square writeback so the check sees the written pw and shifted exponent.
            StSqrWr:  state_next = StCheck;
            StDone:   if (out_free) state_next = StIdle;
            default:  state_next = StIdle;
        endcase
    end

    always_comb begin
        cmd = '0;
        busy = 1'b1;
        done = 1'b0;
        case (state_reg)
            StIdle: begin
                busy = 1'b0;
                cmd.load = in_beat;
            end
            StReduce: cmd.red_step = 1'b1;
            StCheck: begin
                cmd.mul_start = !sts.exp_zero && sts.exp_lsb;
                cmd.sqr_start = !sts.exp_zero && !sts.exp_lsb;
            end
            StMul: begin
                cmd.mm_step   = 1'b1;
                cmd.mul_wr    = 1'b0;
            end
            StSqrGo: cmd.sqr_start = 1'b1;
            StSqr: cmd.mm_step = 1'b1;
            StSqrWr: ;
            StDone: done = out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ hdl/mexp_seq.sv @@
// Glue between multiplier steps: writes products back at the end of each pass.
// Depends on mexp_pkg.
`default_nettype none
module mexp_seq (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mexp_pkg::mexp_cmd_t cmd_in,
    input  wire mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t      cmd_out
);
    import mexp_pkg::*;
    // Track which product is running so its last step can be followed by writeback.
    logic is_mul_reg, wr_reg, wr_next;

    assign wr_next = cmd_in.mm_step && sts.mm_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            is_mul_reg <= 1'b0;
            wr_reg     <= 1'b0;
        end else begin
            if (cmd_in.mul_start) is_mul_reg <= 1'b1;
            if (cmd_in.sqr_start) is_mul_reg <= 1'b0;
            wr_reg <= wr_next;
        end
    end

    // Writeback happens in the cycle after the final step.
    always_comb begin
        cmd_out = cmd_in;
        cmd_out.mul_wr = wr_reg && is_mul_reg;
        cmd_out.sqr_wr = wr_reg && !is_mul_reg;
        // A square start may share the cycle of the multiply writeback: it reads
        // only pw, which a multiply leaves alone.
        cmd_out.sqr_start = cmd_in.sqr_start;
    end
endmodule
`default_nettype wire

@@ tb/modular_exponentiation_unit_test.sv @@
// Self-checking bench for modular_exponentiation_unit: bases go in over a valid/ready
// channel, results are checked against a square-and-multiply predictor built in here.
// Depends on mexp_pkg and the unit RTL.
`timescale 1ns / 1ps
`default_nettype none
module modular_exponentiation_unit_test;
    import mexp_pkg::*;

    localparam int unsigned WIDTH = 64;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_index = RegExponent;
    logic [63:0]      cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [WIDTH-1:0] s_base = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [WIDTH-1:0] m_power_mod;

    // Predictor copy of the two registers.
    logic [63:0] cur_exponent = 64'd0;
    logic [63:0] cur_modulus = 64'd2;

    logic [WIDTH-1:0] power_queue[$];
    bit failed = 0;
    bit stim_done = 0;

    modular_exponentiation_unit #(.WIDTH(WIDTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_base(s_base),
        .m_valid(m_valid), .m_ready(m_ready), .m_power_mod(m_power_mod)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // (a * b) mod m at full precision; a 128-bit product cannot overflow.
    function automatic logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return 64'(prod % {64'd0, m});
    endfunction

    // Right-to-left square-and-multiply on the low WIDTH bits of everything.
    function automatic logic [WIDTH-1:0] power_mod_of(logic [WIDTH-1:0] base);
        logic [63:0] m, e, pw, acc;
        m = 64'(cur_modulus[WIDTH-1:0]);
        e = 64'(cur_exponent[WIDTH-1:0]);
        if (m < 2) m = 2;
        pw = 64'(base) % m;
        acc = 1;
        while (e != 0) begin
            if (e[0]) acc = mul_mod(acc, pw, m);
            e = e >> 1;
            pw = mul_mod(pw, pw, m);
        end
        return acc[WIDTH-1:0];
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    task automatic write_reg(logic idx, logic [63:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == RegExponent) cur_exponent = value;
        else cur_modulus = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Send one base beat; queue its expected result (given, or from the predictor).
    // Valid stays high after an accept unless a gap follows or the bench drains.
    task automatic send_base(logic [WIDTH-1:0] base, bit has_known, logic [WIDTH-1:0] known);
        int unsigned n;
        n = gap_len();
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_base <= base;
        power_queue.push_back(has_known ? known : power_mod_of(base));
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid, hold until every result has come back, then let the unit settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (power_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    typedef struct {
        logic [63:0] exponent;
        logic [63:0] modulus;
        logic [63:0] base;
        bit          has_known;
        logic [63:0] known;
    } dir_row_t;

    localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOPB = 64'h8000_0000_0000_0000;

    dir_row_t dir_rows[] = '{
        // Right after reset: exponent 0 gives 1.
        '{64'd0,  64'd2,  64'd0,  1, 64'd1},
        '{64'd0,  64'd2,  ALL1,   1, 64'd1},
        // Zero exponent with a large modulus and large base.
        '{64'd0,  ALL1,   ALL1,   1, 64'd1},
        // Modulus of 0 or 1 acts as 2.
        '{64'd1,  64'd0,  64'd3,  1, 64'd1},
        '{64'd1,  64'd1,  64'd4,  1, 64'd0},
        '{ALL1,   64'd0,  ALL1,   1, 64'd1},
        // Exponent 1 reduces the base; exponent 2 squares it.
        '{64'd1,  64'd7,  64'd7,  1, 64'd0},
        '{64'd1,  64'd7,  64'd20, 1, 64'd6},
        '{64'd1,  ALL1,   ALL1,   1, 64'd0},
        '{64'd1,  ALL1,   64'd0,  1, 64'd0},
        '{64'd2,  64'd10, 64'd3,  1, 64'd9},
        // Extremes, most of them checked by the predictor.
        '{ALL1,   ALL1,   ALL1-1, 0, 64'd0},
        '{ALL1,   ALL1,   64'd2,  0, 64'd0},
        '{TOPB,   ALL1-58, TOPB,  0, 64'd0},
        '{64'd65537, 64'hC4F8_E9E1_5DCA_DA37, 64'h0123_4567_89AB_CDEF, 0, 64'd0},
        '{ALL1,   TOPB+1, ALL1,   0, 64'd0},
        '{64'd3,  64'd2,  64'd5,  1, 64'd1},
        '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, 64'hAAAA_AAAA_AAAA_AAAA,
          0, 64'd0},
        '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
          0, 64'd0}
    };

    // Result side: randomly stall, check each beat against the oldest expectation.
    initial begin
        logic [WIDTH-1:0] want;
        int unsigned n;
        wait (aresetn);
        forever begin
            n = gap_len();
            if (n != 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (power_queue.size() == 0) begin
                $error("unexpected beat: power_mod=%h", m_power_mod);
                failed = 1;
            end else begin
                want = power_queue.pop_front();
                if (m_power_mod !== want) begin
                    $error("power_mod: expected %h, got %h", want, m_power_mod);
                    failed = 1;
                end
            end
        end
    end

    // Stimulus.
    initial begin
        logic [63:0] e, m;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (dir_rows[i]) begin
            if (i > 0 && (dir_rows[i].exponent != cur_exponent ||
                          dir_rows[i].modulus != cur_modulus)) begin
                drain();
                write_reg(RegExponent, dir_rows[i].exponent);
                write_reg(RegModulus, dir_rows[i].modulus);
            end
            send_base(dir_rows[i].base[WIDTH-1:0], dir_rows[i].has_known,
                      dir_rows[i].known[WIDTH-1:0]);
        end
        // Random phases: new key every few bases, mix of widths and edge moduli.
        for (int p = 0; p < 20; p++) begin
            drain();
            case ($urandom_range(0, 5))
                0: e = 64'($urandom_range(0, 3));
                1: e = ALL1;
                2: e = 64'd65537;
                default: e = rand64();
            endcase
            case ($urandom_range(0, 5))
                0: m = 64'($urandom_range(0, 3));
                1: m = ALL1 - 64'($urandom_range(0, 5));
                2: m = 64'($urandom());
                default: m = rand64();
            endcase
            write_reg(RegExponent, e);
            write_reg(RegModulus, m);
            repeat (5) begin
                case ($urandom_range(0, 7))
                    0: send_base('0, 0, '0);
                    1: send_base('1, 0, '0);
                    2: send_base(m[WIDTH-1:0], 0, '0);
                    default: send_base(rand64(), 0, '0);
                endcase
            end
        end
        drain();
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (!failed && power_queue.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: ~120 bases plus stalls, with large slack.
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ modular_exponentiation_unit.f @@
hdl/mexp_pkg.sv
hdl/mexp_datapath.sv
hdl/mexp_ctrl.sv
hdl/mexp_seq.sv
hdl/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_test.sv
